// File: sv/srht_pkg.sv
// package for the sector / rectangle hit test
// holds widths, register indexes, sequencer states and small helper functions
// no dependencies
package srht_pkg;

  localparam int MAX_BOXES = 1024;
  localparam int IDX_W     = 10;
  localparam int DW        = 24;   // doubled coordinate deviations
  localparam int SQ_W      = 48;   // squares of deviations
  localparam int R2_W      = 38;   // squared radius
  localparam int D2_W      = 49;   // sum of two squares
  localparam int CD_W      = 54;   // cosine times distance squared
  localparam int ACC_W     = 72;   // cosine squared times distance squared
  localparam int IN_W      = 152;
  localparam int OUT_W     = 16;

  // configuration register indexes
  localparam logic REG_CENTER_OFFSET_X = 1'b0;
  localparam logic REG_COS_HALF_ANGLE  = 1'b1;

  localparam logic [2:0] LAST_STEP = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQ,
    ST_CORNER,
    ST_EVAL
  } srht_state_t;

  // magnitude of a signed deviation
  function automatic logic [DW-1:0] abs_dev(input logic [DW-1:0] v);
    abs_dev = v[DW-1] ? (~v + DW'(1)) : v;
  endfunction

  // axis-aligned edge against the circle boundary
  // d_lo / d_hi are the edge ends minus the center along the edge axis
  function automatic logic edge_hit(input logic ok, input logic [SQ_W-1:0] sq_perp,
                                    input logic [SQ_W-1:0] sq_lo,
                                    input logic [SQ_W-1:0] sq_hi,
                                    input logic [DW-1:0] d_lo, input logic [DW-1:0] d_hi,
                                    input logic [R2_W-1:0] r2);
    logic [SQ_W-1:0] near_sq;
    logic [SQ_W-1:0] far_sq;
    logic [D2_W-1:0] mn;
    logic [D2_W-1:0] mx;
    logic [D2_W-1:0] rr;
    if (!d_lo[DW-1] && (d_lo != '0)) near_sq = sq_lo;
    else if (d_hi[DW-1]) near_sq = sq_hi;
    else near_sq = '0;
    far_sq = (sq_lo > sq_hi) ? sq_lo : sq_hi;
    mn = {1'b0, near_sq} + {1'b0, sq_perp};
    mx = {1'b0, far_sq} + {1'b0, sq_perp};
    rr = {{(D2_W-R2_W){1'b0}}, r2};
    edge_hit = ok && (mn <= rr) && (rr <= mx);
  endfunction

endpackage

// File: sv/sector_rectangle_hit_test.sv
// sector / rectangle hit test with sweep tracking of the first hit
// depends on srht_pkg; single shared 24x24 multiplier under a small sequencer

// One transaction on the input gives one result transaction. An item runs
// through the squaring steps, then the multiply steps of the four corner angle
// tests, then a final evaluation step before its result is valid; the block
// then returns to idle before it takes the next item, so a sweep handles one
// item at a time and takes no new item while the previous one is in progress.
// All products go through one 24x24 multiplier. in_tready is high only
// while the sequencer is idle; a finished result waits in the output register
// and does not hold off acceptance of the next item, though that item stays in
// its final evaluation state until the output register is free.
// Configuration may be written only while no item is in flight.

module sector_rectangle_hit_test
  import srht_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // fields from bit 0: apex_x, apex_y, apex_scale, box_x, box_y, box_width,
  // box_height, box_index, zero fill
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tlast,   // final_box
  input  logic             in_tvalid,
  output logic             in_tready,
  // fields from bit 0: box_hit, any_found, first_hit_index, zero fill
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast,  // sweep_done
  output logic             out_tvalid,
  input  logic             out_tready,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [19:0]      cfg_wdata
);

  srht_state_t state_r, state_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [1:0]  corner_r, corner_nxt;

  logic signed [19:0] offset_r;
  logic [15:0]        cos_r;

  logic [DW-1:0]   dxl_r, dxr_r, dyt_r, dyb_r;
  logic [18:0]     scale_r;
  logic            wpos_r, hpos_r;
  logic [IDX_W-1:0] idx_r;
  logic            last_r;
  logic [SQ_W-1:0] sqxl_r, sqxr_r, sqyt_r, sqyb_r;
  logic [R2_W-1:0] r2_r;
  logic [CD_W-1:0] cd_r;
  logic [ACC_W-1:0] acc_r;
  logic            corner_hit_r;

  logic            found_r;
  logic [IDX_W-1:0] first_r;
  logic            out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic            out_last_r;

  logic in_acc, out_free, load_out;

  // input field unpacking
  logic signed [19:0] f_ax, f_ay, f_bx, f_by;
  logic [18:0]        f_sc, f_bw, f_bh;
  assign f_ax = in_tdata[19:0];
  assign f_ay = in_tdata[39:20];
  assign f_sc = in_tdata[58:40];
  assign f_bx = in_tdata[78:59];
  assign f_by = in_tdata[98:79];
  assign f_bw = in_tdata[117:99];
  assign f_bh = in_tdata[136:118];

  // doubled geometry at acceptance
  logic [20:0]   csum;
  logic [DW-1:0] cx2, cy2, bx2, by2, bwe, bhe;
  assign csum = {f_ax[19], f_ax} + {offset_r[19], offset_r};
  assign cx2  = {{2{csum[20]}}, csum, 1'b0};
  assign cy2  = {{3{f_ay[19]}}, f_ay, 1'b0};
  assign bx2  = {{3{f_bx[19]}}, f_bx, 1'b0};
  assign by2  = {{3{f_by[19]}}, f_by, 1'b0};
  assign bwe  = {5'b0, f_bw};
  assign bhe  = {5'b0, f_bh};

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // corner under multiplication
  logic [SQ_W-1:0] m_sqx, m_sqy;
  logic [D2_W-1:0] m_d2;
  assign m_sqx = corner_r[0] ? sqxr_r : sqxl_r;
  assign m_sqy = corner_r[1] ? sqyb_r : sqyt_r;
  assign m_d2  = {1'b0, m_sqx} + {1'b0, m_sqy};

  // shared multiplier operand selection
  logic [DW-1:0]   mul_a, mul_b;
  logic [2*DW-1:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQ: begin
        case (step_r)
          3'd0: begin mul_a = abs_dev(dxl_r); mul_b = abs_dev(dxl_r); end
          3'd1: begin mul_a = abs_dev(dxr_r); mul_b = abs_dev(dxr_r); end
          3'd2: begin mul_a = abs_dev(dyt_r); mul_b = abs_dev(dyt_r); end
          3'd3: begin mul_a = abs_dev(dyb_r); mul_b = abs_dev(dyb_r); end
          default: begin mul_a = {5'b0, scale_r}; mul_b = {5'b0, scale_r}; end
        endcase
      end
      ST_CORNER: begin
        mul_a = {8'b0, cos_r};
        case (step_r)
          3'd0: mul_b = {5'b0, m_d2[18:0]};
          3'd1: mul_b = {5'b0, m_d2[37:19]};
          3'd2: mul_b = {6'b0, cd_r[17:0]};
          3'd3: mul_b = {6'b0, cd_r[35:18]};
          default: mul_b = {6'b0, cd_r[53:36]};
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // corner angle / radius check, one corner behind the multiplier
  logic [1:0]      ev_k;
  logic [DW-1:0]   ev_dx;
  logic [SQ_W-1:0] ev_sqx, ev_sqy;
  logic [D2_W-1:0] ev_d2;
  logic            ev_ok, do_eval;
  always_comb begin
    ev_k   = (state_r == ST_EVAL) ? 2'd3 : (corner_r - 2'd1);
    ev_dx  = ev_k[0] ? dxr_r : dxl_r;
    ev_sqx = ev_k[0] ? sqxr_r : sqxl_r;
    ev_sqy = ev_k[1] ? sqyb_r : sqyt_r;
    ev_d2  = {1'b0, ev_sqx} + {1'b0, ev_sqy};
    ev_ok  = (ev_d2 != '0) && (ev_d2 <= {{(D2_W-R2_W){1'b0}}, r2_r}) && !ev_dx[DW-1] &&
             ({ev_sqx, 30'b0} >= {6'b0, acc_r});
    do_eval = (state_r == ST_CORNER) && (step_r == 3'd0) && (corner_r != 2'd0);
  end

  // edge and center tests in the final evaluation state
  logic edge_any, center_in, hit_f;
  always_comb begin
    edge_any =
      edge_hit(wpos_r, sqyt_r, sqxl_r, sqxr_r, dxl_r, dxr_r, r2_r) ||
      edge_hit(wpos_r, sqyb_r, sqxl_r, sqxr_r, dxl_r, dxr_r, r2_r) ||
      edge_hit(hpos_r, sqxr_r, sqyb_r, sqyt_r, dyb_r, dyt_r, r2_r) ||
      edge_hit(hpos_r, sqxl_r, sqyb_r, sqyt_r, dyb_r, dyt_r, r2_r);
    center_in = (dxl_r[DW-1] || (dxl_r == '0)) && !dxr_r[DW-1] &&
                (dyb_r[DW-1] || (dyb_r == '0)) && !dyt_r[DW-1];
    hit_f = corner_hit_r || ev_ok || edge_any || center_in;
  end

  // next state
  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    corner_nxt = corner_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SQ;
          step_nxt  = '0;
        end
      end
      ST_SQ: begin
        if (step_r == LAST_STEP) begin
          state_nxt  = ST_CORNER;
          step_nxt   = '0;
          corner_nxt = '0;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_CORNER: begin
        if (step_r == LAST_STEP) begin
          step_nxt = '0;
          if (corner_r == 2'd3) state_nxt = ST_EVAL;
          else corner_nxt = corner_r + 2'd1;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_EVAL: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output load strobe
  always_comb begin
    load_out = (state_r == ST_EVAL) && out_free;
  end

  // result fields
  logic             found_new;
  logic [IDX_W-1:0] first_new;
  assign found_new = found_r || hit_f;
  assign first_new = (hit_f && !found_r) ? idx_r : first_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      corner_r     <= '0;
      offset_r     <= 20'sd3200;
      cos_r        <= 16'd28378;
      found_r      <= 1'b0;
      first_r      <= '0;
      out_valid_r  <= 1'b0;
      corner_hit_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      corner_r <= corner_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_CENTER_OFFSET_X: offset_r <= cfg_wdata;
          REG_COS_HALF_ANGLE:  cos_r    <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_acc) corner_hit_r <= 1'b0;
      else if (do_eval && ev_ok) corner_hit_r <= 1'b1;
      if (load_out) begin
        out_valid_r <= 1'b1;
        found_r     <= last_r ? 1'b0 : found_new;
        first_r     <= last_r ? '0 : first_new;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dxl_r   <= (bx2 - bwe) - cx2;
      dxr_r   <= (bx2 + bwe) - cx2;
      dyb_r   <= (by2 - bhe) - cy2;
      dyt_r   <= (by2 + bhe) - cy2;
      scale_r <= f_sc;
      wpos_r  <= (f_bw != '0);
      hpos_r  <= (f_bh != '0);
      idx_r   <= in_tdata[146:137];
      last_r  <= in_tlast;
    end
    if (state_r == ST_SQ) begin
      case (step_r)
        3'd0: sqxl_r <= mul_p;
        3'd1: sqxr_r <= mul_p;
        3'd2: sqyt_r <= mul_p;
        3'd3: sqyb_r <= mul_p;
        default: r2_r <= mul_p[R2_W-1:0];
      endcase
    end
    if (state_r == ST_CORNER) begin
      case (step_r)
        3'd0: cd_r  <= CD_W'(mul_p);
        3'd1: cd_r  <= cd_r + {mul_p[34:0], 19'b0};
        3'd2: acc_r <= ACC_W'(mul_p);
        3'd3: acc_r <= acc_r + {6'b0, mul_p, 18'b0};
        default: acc_r <= acc_r + {mul_p[35:0], 36'b0};
      endcase
    end
    if (load_out) begin
      out_data_r <= {4'b0, (found_new ? first_new : {IDX_W{1'b0}}), found_new, hit_f};
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a second item while busy");

  a_hit_sets_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1])
    else $error("hit without found flag");

  a_no_index_unfound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> out_tdata[11:2] == '0)
    else $error("first index set without a hit");

endmodule
